### sv/sid_pkg.sv
`timescale 1ns / 1ps

package sid_pkg;

	localparam int ID_W     = 32;
	localparam int STATUS_W = 3;
	localparam int CMD_W    = 2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

	// Configuration register indexes
	localparam logic CFG_LOW  = 1'b0;
	localparam logic CFG_HIGH = 1'b1;

	localparam logic signed [ID_W-1:0] LOW_RESET  = 32'sd1;
	localparam logic signed [ID_W-1:0] HIGH_RESET = 32'sd1234567890;

	// One result beat handed to the output register
	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic signed [ID_W-1:0] ident;
		logic                   valid;
		logic                   last;
	} res_t;

endpackage

### sv/sid_mem.sv
`timescale 1ns / 1ps

module sid_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic [sid_pkg::ID_W-1:0] wdata,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        raddr,
	output logic [sid_pkg::ID_W-1:0] rdata
);
	import sid_pkg::*;

	logic [ID_W-1:0] mem [DEPTH];

	// Write one entry, read one entry; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/sid_outreg.sv
`timescale 1ns / 1ps

module sid_outreg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  sid_pkg::res_t                res,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [sid_pkg::STATUS_W-1:0] status,
	output logic signed [sid_pkg::ID_W-1:0] entry_ident,
	output logic                         entry_valid,
	output logic                         last,
	output logic                         free
);
	import sid_pkg::*;

	logic out_valid_q;
	res_t res_q;

	// Register can take a new beat when empty or being drained this cycle
	assign free = !out_valid_q || !out_stall;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign entry_ident = res_q.ident;
	assign entry_valid = res_q.valid;
	assign last        = res_q.last;

endmodule

### sv/sorted_id_set.sv
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// cfg     | cfg_we               | cfg_idx, cfg_wdata
// in      | in_valid / in_stall  | command, ident
// out     | out_valid / out_stall| status, entry_ident, entry_valid, last
//
// One command at a time; entries live in a single-port-read, single-port-write RAM.
// Insert: scan one entry per cycle, then shift one entry per cycle through the RAM
// read-to-write path; remove: the same scan, then a shift the other way.
// Reset clears the entry count and loads the limit registers; RAM is not cleared.
// A stalled output holds the current beat; the next command is taken meanwhile.

module sorted_id_set #(
	parameter int CAPACITY = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [sid_pkg::ID_W-1:0]     cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sid_pkg::CMD_W-1:0]    command,
	input  logic signed [sid_pkg::ID_W-1:0] ident,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sid_pkg::STATUS_W-1:0] status,
	output logic signed [sid_pkg::ID_W-1:0] entry_ident,
	output logic                         entry_valid,
	output logic                         last
);
	import sid_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SHIFT,
		S_LIST,
		S_RESULT
	} state_t;

	state_t state_q;
	logic [CMD_W-1:0] cmd_q;
	logic signed [ID_W-1:0] id_q;
	logic signed [ID_W-1:0] low_q;
	logic signed [ID_W-1:0] high_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] pos_q;
	logic more_q;
	logic dir_up_q;
	logic [STATUS_W-1:0] res_status_q;
	logic rvalid_s1;
	logic [CNT_W-1:0] ridx_s1;

	logic [ID_W-1:0] rdata;
	logic mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [ID_W-1:0] mem_wdata;

	logic accept, in_range, hit, miss, eq;
	logic scan_issue, shift_issue, shift_done, list_start, list_adv, list_last;
	logic [CNT_W-1:0] scan_pos, rd_nxt, wa_up, wa_dn;
	logic out_free, out_load;
	res_t out_res;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Range and compare logic
	assign in_range = (id_q >= low_q) && (id_q <= high_q);
	assign eq       = (rdata == id_q);
	assign hit      = rvalid_s1 && ($signed(rdata) >= id_q);
	assign miss     = !hit && (rd_ptr_q == count_q);
	assign scan_pos = hit ? ridx_s1 : count_q;
	assign rd_nxt   = rd_ptr_q + ONE_C;
	assign wa_up    = ridx_s1 + ONE_C;
	assign wa_dn    = ridx_s1 - ONE_C;

	// Read issue conditions
	assign scan_issue  = (state_q == S_SCAN) && !hit && !miss;
	assign shift_issue = (state_q == S_SHIFT) && more_q;
	assign shift_done  = (state_q == S_SHIFT) && !more_q && !rvalid_s1;
	assign list_start  = (state_q == S_CHECK) && (cmd_q == CMD_LIST) && (count_q != '0);
	assign list_last   = (rd_ptr_q == count_q - ONE_C);
	assign list_adv    = (state_q == S_LIST) && out_free && !list_last;

	assign mem_re    = scan_issue || shift_issue || list_start || list_adv;
	assign mem_raddr = list_adv ? rd_nxt[ADDR_W-1:0] : rd_ptr_q[ADDR_W-1:0];

	// Write port: move shifted entry, or drop the new identifier into place
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_up[ADDR_W-1:0];
		mem_wdata = rdata;
		if (state_q == S_SHIFT && rvalid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = dir_up_q ? wa_up[ADDR_W-1:0] : wa_dn[ADDR_W-1:0];
		end else if (shift_done && dir_up_q) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q[ADDR_W-1:0];
			mem_wdata = id_q;
		end
	end

	// Pick the result beat
	always_comb begin
		out_load = 1'b0;
		out_res  = '{status: res_status_q, ident: '0, valid: 1'b0, last: 1'b1};
		if (state_q == S_LIST && out_free) begin
			out_load = 1'b1;
			out_res  = '{status: ST_OK, ident: $signed(rdata), valid: 1'b1, last: list_last};
		end else if (state_q == S_RESULT && out_free) begin
			out_load = 1'b1;
		end
	end

	// Hold the limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LOW:  low_q  <= $signed(cfg_wdata);
				CFG_HIGH: high_q <= $signed(cfg_wdata);
				default:  ;
			endcase
		end
	end

	// Latch the command beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			id_q  <= ident;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			pos_q        <= '0;
			more_q       <= 1'b0;
			dir_up_q     <= 1'b0;
			res_status_q <= ST_OK;
			rvalid_s1    <= 1'b0;
			ridx_s1      <= '0;
		end else begin
			rvalid_s1 <= scan_issue || shift_issue;
			ridx_s1   <= rd_ptr_q;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_ptr_q <= '0;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					res_status_q <= ST_OK;
					if (cmd_q == CMD_INSERT || cmd_q == CMD_REMOVE) begin
						if (!in_range) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (list_start) begin
						state_q <= S_LIST;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_SCAN: begin
					if (hit || miss) begin
						if (cmd_q == CMD_INSERT) begin
							if (hit && eq) begin
								res_status_q <= ST_DUP;
								state_q      <= S_RESULT;
							end else if (count_q == CAP_C) begin
								res_status_q <= ST_FULL;
								state_q      <= S_RESULT;
							end else begin
								pos_q    <= scan_pos;
								rd_ptr_q <= count_q - ONE_C;
								more_q   <= (scan_pos < count_q);
								dir_up_q <= 1'b1;
								state_q  <= S_SHIFT;
							end
						end else if (hit && eq) begin
							rd_ptr_q <= ridx_s1 + ONE_C;
							more_q   <= ((ridx_s1 + ONE_C) < count_q);
							dir_up_q <= 1'b0;
							state_q  <= S_SHIFT;
						end else begin
							res_status_q <= ST_ABSENT;
							state_q      <= S_RESULT;
						end
					end else begin
						rd_ptr_q <= rd_nxt;
					end
				end
				S_SHIFT: begin
					// Advance the read pointer until the last entry to move is read
					if (more_q) begin
						if (dir_up_q) begin
							if (rd_ptr_q == pos_q) begin
								more_q <= 1'b0;
							end else begin
								rd_ptr_q <= rd_ptr_q - ONE_C;
							end
						end else begin
							if (rd_ptr_q == count_q - ONE_C) begin
								more_q <= 1'b0;
							end else begin
								rd_ptr_q <= rd_nxt;
							end
						end
					end else if (!rvalid_s1) begin
						count_q      <= dir_up_q ? count_q + ONE_C : count_q - ONE_C;
						res_status_q <= ST_OK;
						state_q      <= S_RESULT;
					end
				end
				S_LIST: begin
					if (out_free) begin
						if (list_last) begin
							state_q <= S_IDLE;
						end else begin
							rd_ptr_q <= rd_nxt;
						end
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sid_mem #(
		.DEPTH (CAPACITY),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	sid_outreg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (out_load),
		.res        (out_res),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.entry_ident(entry_ident),
		.entry_valid(entry_valid),
		.last       (last),
		.free       (out_free)
	);

	// Entry count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count beyond capacity");

	// Writes never land past the first free slot
	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNT_W'(mem_waddr) <= count_q))
		else $error("table write beyond filled region");

	// Count only moves at the end of a shift
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SHIFT) |=> $stable(count_q))
		else $error("entry count changed outside shift");

	// A new result is loaded only when the output register can take it
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !out_load)
		else $error("result overwrote a stalled beat");

endmodule
